/* rtl/gcg_pkg.sv */
// ----------------------------------------------------------------------------
// gcg_pkg
// Shared constants, command/status types and LFSR helpers for the Gold code
// chip generator.
// ----------------------------------------------------------------------------
package gcg_pkg;

    // Longest LFSR supported and the width of the stage count register
    localparam int MAX_STAGES = 16;
    localparam int MIN_STAGES = 3;
    localparam int STG_W      = 5;
    localparam int PRN_SHIFT  = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_STAGES = 2'd0;
    localparam logic [1:0] CFG_G1_TAPS    = 2'd1;
    localparam logic [1:0] CFG_G2_TAPS    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [STG_W-1:0]      RST_NUM_STAGES = 5'd10;
    localparam logic [MAX_STAGES-1:0] RST_G1_TAPS    = 16'd516;
    localparam logic [MAX_STAGES-1:0] RST_G2_TAPS    = 16'd934;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // restart: reload LFSRs, load alignment count
        logic align_step;  // advance G2 once, count down
        logic emit;        // register one chip, step both LFSRs
        logic reject;      // register a rejected-PRN word
    } gcg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic prn_bad;     // incoming PRN is out of range
        logic align_zero;  // no alignment steps left
    } gcg_stat_t;

    // Clamp the stage count into the supported range
    function automatic logic [STG_W-1:0] eff_stages(input logic [STG_W-1:0] ns);
        logic [STG_W-1:0] s;
        s = ns;
        if (ns < STG_W'(MIN_STAGES)) s = STG_W'(MIN_STAGES);
        if (ns > STG_W'(MAX_STAGES)) s = STG_W'(MAX_STAGES);
        return s;
    endfunction

    // Ones in the used stages; equals the period
    function automatic logic [MAX_STAGES-1:0] stage_mask(input logic [STG_W-1:0] s);
        logic [MAX_STAGES:0] m;
        m = ({{MAX_STAGES{1'b0}}, 1'b1} << s) - {{MAX_STAGES{1'b0}}, 1'b1};
        return m[MAX_STAGES-1:0];
    endfunction

    // One right shift of a Fibonacci LFSR, feedback into the top used stage
    function automatic logic [MAX_STAGES-1:0] lfsr_next(
        input logic [MAX_STAGES-1:0] reg_in,
        input logic [MAX_STAGES-1:0] taps,
        input logic [STG_W-1:0]      s
    );
        logic [MAX_STAGES-1:0] r;
        logic                  fb;
        logic [3:0]            top;
        r   = reg_in & stage_mask(s);
        fb  = r[0];
        top = 4'(s - 5'd1);
        // power k+1 taps stage s-1-k
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (k < int'(s)) begin
                fb = fb ^ (taps[k] & r[4'(int'(s) - 1 - k)]);
            end
        end
        return (r >> 1) | (MAX_STAGES'(fb) << top);
    endfunction

endpackage

/* rtl/gcg_datapath.sv */
// ----------------------------------------------------------------------------
// gcg_datapath
// Configuration registers, the two LFSRs, chip position, alignment counter
// and the output word register.
// ----------------------------------------------------------------------------
module gcg_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [gcg_pkg::MAX_STAGES-1:0] cfg_data,
    input  logic [gcg_pkg::MAX_STAGES-1:0] prn_code,
    input  gcg_pkg::gcg_cmd_t              cmd,
    output gcg_pkg::gcg_stat_t             stat,
    output logic                           chip,
    output logic [gcg_pkg::MAX_STAGES-1:0] chip_index,
    output logic                           last_chip,
    output logic                           prn_rejected
);

    localparam int W = gcg_pkg::MAX_STAGES;

    logic [gcg_pkg::STG_W-1:0] num_stages_reg;
    logic [W-1:0]              g1_taps_reg;
    logic [W-1:0]              g2_taps_reg;
    logic [W-1:0]              g1_reg, g1_next;
    logic [W-1:0]              g2_reg, g2_next;
    logic [W-1:0]              pos_reg, pos_next;
    logic [W-1:0]              align_reg, align_next;
    logic                      chip_reg, chip_next;
    logic [W-1:0]              index_reg, index_next;
    logic                      last_reg, last_next;
    logic                      rej_reg, rej_next;

    logic [gcg_pkg::STG_W-1:0] stages;
    logic [W-1:0]              period;
    logic [3:0]                top;
    logic [W:0]                prn_sum;
    logic [W:0]                pos_inc;
    logic [W-1:0]              align_calc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_stages_reg <= gcg_pkg::RST_NUM_STAGES;
            g1_taps_reg    <= gcg_pkg::RST_G1_TAPS;
            g2_taps_reg    <= gcg_pkg::RST_G2_TAPS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gcg_pkg::CFG_NUM_STAGES: num_stages_reg <= cfg_data[gcg_pkg::STG_W-1:0];
                gcg_pkg::CFG_G1_TAPS:    g1_taps_reg    <= cfg_data;
                gcg_pkg::CFG_G2_TAPS:    g2_taps_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Derived stage values
    assign stages     = gcg_pkg::eff_stages(num_stages_reg);
    assign period     = gcg_pkg::stage_mask(stages);
    assign top        = 4'(stages - 5'd1);
    assign prn_sum    = {1'b0, prn_code} + (W+1)'(gcg_pkg::PRN_SHIFT);
    assign pos_inc    = {1'b0, pos_reg} + {{W{1'b0}}, 1'b1};
    // prn + 3 <= period here, so no wrap is needed
    assign align_calc = period - prn_sum[W-1:0];

    assign stat.prn_bad    = prn_sum >= ({{W{1'b0}}, 1'b1} << stages);
    assign stat.align_zero = (align_reg == '0);

    // Next-state logic
    always_comb
    begin
        g1_next    = g1_reg;
        g2_next    = g2_reg;
        pos_next   = pos_reg;
        align_next = align_reg;
        chip_next  = chip_reg;
        index_next = index_reg;
        last_next  = last_reg;
        rej_next   = rej_reg;
        if (cmd.load)
        begin
            g1_next    = period;
            g2_next    = period;
            pos_next   = '0;
            align_next = align_calc;
        end
        if (cmd.align_step)
        begin
            g2_next    = gcg_pkg::lfsr_next(g2_reg, g2_taps_reg, stages);
            align_next = align_reg - {{(W-1){1'b0}}, 1'b1};
        end
        if (cmd.emit)
        begin
            chip_next  = g1_reg[top] ^ g2_reg[top];
            index_next = pos_reg;
            last_next  = (pos_reg == (period - {{(W-1){1'b0}}, 1'b1}));
            rej_next   = 1'b0;
            g1_next    = gcg_pkg::lfsr_next(g1_reg, g1_taps_reg, stages);
            g2_next    = gcg_pkg::lfsr_next(g2_reg, g2_taps_reg, stages);
            pos_next   = (pos_inc >= {1'b0, period}) ? '0 : pos_inc[W-1:0];
        end
        if (cmd.reject)
        begin
            chip_next  = 1'b0;
            index_next = '0;
            last_next  = 1'b0;
            rej_next   = 1'b1;
        end
    end

    // Code state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg    <= gcg_pkg::stage_mask(gcg_pkg::RST_NUM_STAGES);
            g2_reg    <= gcg_pkg::stage_mask(gcg_pkg::RST_NUM_STAGES);
            pos_reg   <= '0;
            align_reg <= '0;
        end
        else
        begin
            g1_reg    <= g1_next;
            g2_reg    <= g2_next;
            pos_reg   <= pos_next;
            align_reg <= align_next;
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        chip_reg  <= chip_next;
        index_reg <= index_next;
        last_reg  <= last_next;
        rej_reg   <= rej_next;
    end

    assign chip         = chip_reg;
    assign chip_index   = index_reg;
    assign last_chip    = last_reg;
    assign prn_rejected = rej_reg;

endmodule

/* rtl/gcg_ctrl.sv */
// ----------------------------------------------------------------------------
// gcg_ctrl
// Controller: input/output handshakes and the restart alignment sequence.
// ----------------------------------------------------------------------------
module gcg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    input  gcg_pkg::gcg_stat_t stat,
    output gcg_pkg::gcg_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_ALIGN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    // Output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Sequencing
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!restart)
                    begin
                        cmd.emit       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else if (stat.prn_bad)
                    begin
                        cmd.reject     = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (stat.align_zero)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.align_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A word is never written over one that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.reject) |-> slot_free)
        else $error("gcg_ctrl: output word overwritten");

    // No input is taken during alignment
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN) |-> !in_ready)
        else $error("gcg_ctrl: input accepted during alignment");

    // A good restart always enters alignment
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart && !stat.prn_bad) |=> (state_reg == ST_ALIGN))
        else $error("gcg_ctrl: restart skipped alignment");

    // Alignment and emission never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.align_step |-> (!cmd.emit && !cmd.load && !out_valid_next))
        else $error("gcg_ctrl: alignment step overlaps a chip");
`endif

endmodule

/* rtl/gold_code_chip_generator.sv */
// The output word for a next-chip word or a rejected PRN is registered in the
// cycle after the input word is taken. Throughput: one chip per cycle while
// the output side keeps taking words and no restart is aligning. A restart
// reloads the LFSRs and makes A = (2^stages-1) - prn - 3 G2 steps, one a cycle.
// Reset (rst_n, asynchronous, active low): stages 10, taps 516/934, both
// LFSRs all ones, chip position zero, no word pending.
// ----------------------------------------------------------------------------
// gold_code_chip_generator
// Gold code chip generator from two configurable Fibonacci LFSRs with
// PRN-selected G2 phase.
// ----------------------------------------------------------------------------
module gold_code_chip_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [gcg_pkg::MAX_STAGES-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           restart,
    input  logic [gcg_pkg::MAX_STAGES-1:0] prn_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           chip,
    output logic [gcg_pkg::MAX_STAGES-1:0] chip_index,
    output logic                           last_chip,
    output logic                           prn_rejected
);

    gcg_pkg::gcg_cmd_t  cmd;
    gcg_pkg::gcg_stat_t stat;

    // Controller
    gcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    gcg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .prn_code     (prn_code),
        .cmd          (cmd),
        .stat         (stat),
        .chip         (chip),
        .chip_index   (chip_index),
        .last_chip    (last_chip),
        .prn_rejected (prn_rejected)
    );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: Gold code chip generator testbench
// Sends restart and next-chip words into the generator and predicts every
// chip word with a local two-LFSR model. Each output word is checked field by
// field, in order. The run covers the stage count limits, taps above the
// stage count, rejected PRNs and a stage change in the middle of a code.
// Random phases follow with random settings. Both sides idle at random, and
// one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE   = 2'd3;   // index with no register behind it
    localparam int         CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        chip_bit;
        logic [15:0] position;
        logic        period_end;
        logic        rejected;
    } chip_word_t;

    // DUT ports
    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [1:0]                     cfg_index;
    logic [gcg_pkg::MAX_STAGES-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           restart;
    logic [gcg_pkg::MAX_STAGES-1:0] prn_code;
    logic                           out_valid;
    logic                           out_ready;
    logic                           chip;
    logic [gcg_pkg::MAX_STAGES-1:0] chip_index;
    logic                           last_chip;
    logic                           prn_rejected;

    // Local copy of the generator settings and state
    logic [4:0]  stages_cfg  = gcg_pkg::RST_NUM_STAGES;
    logic [15:0] g1_taps_cfg = gcg_pkg::RST_G1_TAPS;
    logic [15:0] g2_taps_cfg = gcg_pkg::RST_G2_TAPS;
    logic [15:0] g1_reg      = 16'h03FF;
    logic [15:0] g2_reg      = 16'h03FF;
    int          chip_pos    = 0;

    chip_word_t expected_chips[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    bit         tx_throttle    = 1'b1;
    bit         rx_throttle    = 1'b1;
    int         hold_req       = 0;

    gold_code_chip_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .prn_code     (prn_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chip         (chip),
        .chip_index   (chip_index),
        .last_chip    (last_chip),
        .prn_rejected (prn_rejected)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stage count register value as the LFSRs use it
    function automatic int used_stages(input logic [4:0] raw);
        int s;
        s = int'(raw);
        if (s < gcg_pkg::MIN_STAGES) s = gcg_pkg::MIN_STAGES;
        if (s > gcg_pkg::MAX_STAGES) s = gcg_pkg::MAX_STAGES;
        return s;
    endfunction

    // One right shift; feedback is bit 0 plus bit s-p for each power p
    function automatic logic [15:0] shift_lfsr(input logic [15:0] r_in,
                                               input logic [15:0] taps,
                                               input int s);
        logic [15:0] r;
        logic        fb;
        r  = r_in & 16'((1 << s) - 1);
        fb = r[0];
        for (int p = 1; p <= s; p++)
        begin
            if (taps[p-1]) fb = fb ^ r[s-p];
        end
        r      = r >> 1;
        r[s-1] = fb;
        return r;
    endfunction

    // Chip word for one accepted input word; updates the local state
    function automatic chip_word_t advance_code(input logic rs, input logic [15:0] prn);
        int         s;
        int         period;
        int         steps;
        chip_word_t w;
        s      = used_stages(stages_cfg);
        period = (1 << s) - 1;
        w      = '0;
        if (rs)
        begin
            // out-of-range PRN: flag only, state untouched
            if (int'(prn) + gcg_pkg::PRN_SHIFT >= (1 << s))
            begin
                w.rejected = 1'b1;
                return w;
            end
            g1_reg   = 16'(period);
            g2_reg   = 16'(period);
            chip_pos = 0;
            steps    = (period - int'(prn) - gcg_pkg::PRN_SHIFT) % period;
            for (int k = 0; k < steps; k++)
                g2_reg = shift_lfsr(g2_reg, g2_taps_cfg, s);
        end
        w.chip_bit   = g1_reg[s-1] ^ g2_reg[s-1];
        w.position   = 16'(chip_pos);
        w.period_end = (chip_pos == period - 1);
        g1_reg   = shift_lfsr(g1_reg, g1_taps_cfg, s);
        g2_reg   = shift_lfsr(g2_reg, g2_taps_cfg, s);
        chip_pos = chip_pos + 1;
        if (chip_pos >= period) chip_pos = 0;
        return w;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Restart PRN: keeps alignment short for long LFSRs, some rejected
    function automatic logic [15:0] pick_prn(input int s);
        int top;
        int r;
        top = (1 << s) - 4;
        r   = $urandom_range(0, 99);
        if (r < 8) return 16'($urandom_range(top + 1, 65535));
        if (s <= 10 && r < 60) return 16'($urandom_range(0, top));
        return 16'(top - $urandom_range(0, (top < 200) ? top : 200));
    endfunction

    // Offer one word and wait for it to be taken
    task automatic offer_word(input logic rs, input logic [15:0] prn);
        int         gap;
        chip_word_t w;
        gap = tx_throttle ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        prn_code <= prn;
        do @(posedge clk); while (!in_ready);
        w              = advance_code(rs, prn);
        expected_chips = {expected_chips, w};
    endtask

    // Stop sending and let every pending word drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_chips.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register write, only while idle
    task automatic set_register(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            gcg_pkg::CFG_NUM_STAGES: stages_cfg  = data[4:0];
            gcg_pkg::CFG_G1_TAPS:    g1_taps_cfg = data;
            gcg_pkg::CFG_G2_TAPS:    g2_taps_cfg = data;
            default:                 ;
        endcase
    endtask

    // Reset settings: free-running chips, restarts, alignment of zero, rejection
    task automatic test_reset_values();
        offer_word(1'b0, 16'hFFFF);
        offer_word(1'b0, 16'h0000);
        offer_word(1'b1, 16'd0);
        offer_word(1'b0, 16'($urandom));
        offer_word(1'b0, 16'($urandom));
        offer_word(1'b1, 16'd1020);
        offer_word(1'b1, 16'd1021);
        offer_word(1'b0, 16'($urandom));
    endtask

    // Stage count clamping at both ends, taps above the stage count
    task automatic test_stage_limits();
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'd0);
        set_register(gcg_pkg::CFG_G1_TAPS, 16'h0002);
        set_register(gcg_pkg::CFG_G2_TAPS, 16'hFFFB);
        set_register(CFG_SPARE, 16'hFFFF);
        offer_word(1'b1, 16'd4);
        offer_word(1'b1, 16'd5);
        offer_word(1'b1, 16'd0);
        repeat (7) offer_word(1'b0, 16'($urandom));

        // junk above the 5-bit field: reads as 31, clamps to 16 stages
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'hFFFF);
        set_register(gcg_pkg::CFG_G1_TAPS, 16'hB400);
        set_register(gcg_pkg::CFG_G2_TAPS, 16'h8016);
        offer_word(1'b1, 16'd0);
        offer_word(1'b0, 16'($urandom));
        offer_word(1'b1, 16'd65532);
        offer_word(1'b1, 16'd65533);
        offer_word(1'b1, 16'd65535);
    endtask

    // Shrink the period while the position is already past it
    task automatic test_stage_change();
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'd4);
        set_register(gcg_pkg::CFG_G1_TAPS, 16'h0009);
        set_register(gcg_pkg::CFG_G2_TAPS, 16'h000C);
        offer_word(1'b1, 16'd0);
        repeat (9) offer_word(1'b0, 16'($urandom));
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'd3);
        repeat (3) offer_word(1'b0, 16'($urandom));
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'd16);
        repeat (2) offer_word(1'b0, 16'($urandom));
    endtask

    // Random settings per phase, each phase mostly a restart then chips
    task automatic test_random_codes();
        int         total;
        int         phase_len;
        int         r;
        logic [4:0] st;
        total = 0;
        while (total < 1200)
        begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 5)       st = 5'($urandom_range(0, 2));
            else if (r < 10) st = 5'($urandom_range(17, 31));
            else if (r < 15) st = 5'd16;
            else if (r < 25) st = 5'($urandom_range(11, 15));
            else             st = 5'($urandom_range(3, 10));
            set_register(gcg_pkg::CFG_NUM_STAGES, {11'($urandom), st});
            if ($urandom_range(0, 9) < 7)
                set_register(gcg_pkg::CFG_G1_TAPS, 16'($urandom));
            if ($urandom_range(0, 9) < 7)
                set_register(gcg_pkg::CFG_G2_TAPS, 16'($urandom));
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(30, 90);
            if ($urandom_range(0, 9) != 0)
                offer_word(1'b1, pick_prn(used_stages(stages_cfg)));
            for (int i = 0; i < phase_len; i++)
            begin
                if ($urandom_range(0, 99) < 10)
                    offer_word(1'b1, pick_prn(used_stages(stages_cfg)));
                else
                    offer_word(1'b0, 16'($urandom));
            end
            total = total + phase_len + 1;
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_receiver_hold();
        wait_idle();
        set_register(gcg_pkg::CFG_NUM_STAGES, 16'd7);
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
        hold_req    = 300;
        offer_word(1'b1, 16'd50);
        repeat (60) offer_word(1'b0, 16'($urandom));
    endtask

    // Receiver ready: hold-off requests first, then random stalls
    initial
    begin : rx_ready_gen
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_throttle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // Check every chip word taken from the block against the oldest prediction
    initial
    begin : chip_checker
        chip_word_t exp_w;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_chips.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: chip=%0b idx=%0d last=%0b rej=%0b",
                                 chip, chip_index, last_chip, prn_rejected);
                end
                else
                begin
                    exp_w = expected_chips.pop_front();
                    if (chip !== exp_w.chip_bit || chip_index !== exp_w.position ||
                        last_chip !== exp_w.period_end || prn_rejected !== exp_w.rejected)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch at %0t: exp chip=%0b idx=%0d last=%0b rej=%0b",
                                      " got chip=%0b idx=%0d last=%0b rej=%0b"}, $realtime,
                                     exp_w.chip_bit, exp_w.position, exp_w.period_end,
                                     exp_w.rejected, chip, chip_index, last_chip,
                                     prn_rejected);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Test sequence
    initial
    begin : main_seq
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= gcg_pkg::CFG_NUM_STAGES;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        prn_code  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_stage_limits();
        test_stage_change();
        test_random_codes();
        test_receiver_hold();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* gold_code_chip_generator.f */
rtl/gcg_pkg.sv
rtl/gcg_datapath.sv
rtl/gcg_ctrl.sv
rtl/gold_code_chip_generator.sv
bench/tb_top.sv
